FILE: hdl/stcr_pkg.sv
`timescale 1ns / 1ps

package stcr_pkg;

  // Default capacity of the chunk store in samples.
  localparam int MAX_CHUNK_DEF = 2048;

  // Widths of the fixed item fields and registers.
  localparam int RAW_W      = 32;
  localparam int SAMPLE_W   = 16;
  localparam int INDEX_W    = 11;
  localparam int CHUNKNUM_W = 8;
  localparam int SHIFT_W    = 5;
  localparam int LEN_W      = 12;
  localparam int ALPHA_W    = 17;
  localparam int AMP_W      = 16;
  localparam int ENERGY_W   = 42;
  localparam int COUNT_W    = 12;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 42;
  localparam int MIX_W      = 35;
  localparam int SQ_W       = 31;

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_SHIFT     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CHUNK_LENGTH     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DC_ALPHA_Q16     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_AMP_THRESHOLD    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ENERGY_THRESHOLD = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_COUNT_MIN = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_RECORDING_CHUNKS = 3'd6;

  // Register values after reset.
  localparam logic [SHIFT_W-1:0]    RST_SAMPLE_SHIFT     = 5'd14;
  localparam logic [LEN_W-1:0]      RST_CHUNK_LENGTH     = 12'd1600;
  localparam logic [ALPHA_W-1:0]    RST_DC_ALPHA_Q16     = 17'd65208;
  localparam logic [AMP_W-1:0]      RST_AMP_THRESHOLD    = 16'd1000;
  localparam logic [ENERGY_W-1:0]   RST_ENERGY_THRESHOLD = 42'd1600000000;
  localparam logic [COUNT_W-1:0]    RST_ACTIVE_COUNT_MIN = 12'd240;
  localparam logic [CHUNKNUM_W-1:0] RST_RECORDING_CHUNKS = 8'd50;

  localparam logic [ALPHA_W-1:0] ALPHA_ONE = 17'd65536;
  localparam logic signed [31:0] SAT_MAX = 32'sd32767;
  localparam logic signed [31:0] SAT_MIN = -32'sd32768;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_UPD,
    S_SQ,
    S_END
  } state_t;

endpackage

FILE: hdl/stcr_ram.sv
`timescale 1ns / 1ps

module stcr_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: hdl/sound_triggered_chunk_recorder_core.sv
`timescale 1ns / 1ps

// Sound-triggered chunk recorder.
// Input channel: one raw 32-bit audio word per item (in_valid / in_stall).
// Result channel: at most one stored sample per input item (out_valid /
// out_stall), carrying its index in the chunk, its chunk number in the
// recording and first/last flags. A chunk chosen for sending comes out one
// chunk late, one sample for each input item of the following chunk.
// Configuration: cfg_we writes cfg_wdata into register cfg_index; write only
// while the block is idle.
// Each item runs a step through the chunk store read, the DC multiply, the
// divide and store write-back, the square and the energy accumulate with the
// trigger compare, in that order, and the DC and chunk state that the next
// item needs is complete only at the end, so a new item is taken only after it.
// A result is loaded into the output register in the write-back step.
// The output register lets a new item be accepted while a result waits; an
// item that has a result to deliver holds in the write-back step while the
// receiver stalls and the output register is still full.
// Reset (synchronous, rst_n low) restores the register defaults, clears the
// DC estimate, the chunk position and the recording state, and empties the
// output register. The chunk store needs no clearing: only written entries
// are ever sent.
module sound_triggered_chunk_recorder_core
  import stcr_pkg::*;
#(
  parameter int MAX_CHUNK = MAX_CHUNK_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic signed [RAW_W-1:0]      in_raw_word,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic signed [SAMPLE_W-1:0]   out_sample,
  output logic [INDEX_W-1:0]           out_sample_index,
  output logic [CHUNKNUM_W-1:0]        out_chunk_number,
  output logic                         out_first_of_recording,
  output logic                         out_last_of_chunk,
  input  logic                         cfg_we,
  input  logic [CFG_IDX_W-1:0]         cfg_index,
  input  logic [CFG_DATA_W-1:0]        cfg_wdata
);

  // Position width indexes the store; length width holds MAX_CHUNK itself.
  localparam int PW = $clog2(MAX_CHUNK);
  localparam int LW = $clog2(MAX_CHUNK + 1);

  // Configuration registers.
  logic [SHIFT_W-1:0]    cfg_shift_r;
  logic [LEN_W-1:0]      cfg_len_r;
  logic [ALPHA_W-1:0]    cfg_alpha_r;
  logic [AMP_W-1:0]      cfg_amp_r;
  logic [ENERGY_W-1:0]   cfg_energy_r;
  logic [COUNT_W-1:0]    cfg_count_min_r;
  logic [CHUNKNUM_W-1:0] cfg_rec_chunks_r;

  // Control and datapath state.
  state_t state_r, state_nxt;
  logic [PW-1:0]           pos_r;
  logic signed [SAMPLE_W-1:0] dc_r;
  logic [ENERGY_W-1:0]     energy_r;
  logic [COUNT_W-1:0]      count_r;
  logic                    rec_r;
  logic [CHUNKNUM_W-1:0]   sent_r;
  logic                    emit_r;
  logic [CHUNKNUM_W-1:0]   pnum_r;
  logic [LW-1:0]           plen_r;

  logic signed [SAMPLE_W-1:0] x_r;
  logic signed [MIX_W-1:0]    mix_r;
  logic signed [SAMPLE_W-1:0] stored_r;
  logic [SQ_W-1:0]            sq_r;
  logic                       act_r;

  logic                       out_valid_r;
  logic signed [SAMPLE_W-1:0] out_sample_r;
  logic [INDEX_W-1:0]         out_index_r;
  logic [CHUNKNUM_W-1:0]      out_num_r;
  logic                       out_first_r;
  logic                       out_last_r;

  // Control outputs of the sequencer.
  logic ram_re, ram_we, upd_go, in_accept;

  logic [SAMPLE_W-1:0] ram_rdata;

  // Shift and saturate the incoming word.
  logic signed [RAW_W-1:0]    shifted;
  logic signed [SAMPLE_W-1:0] x_sat;

  always_comb begin
    shifted = in_raw_word >>> cfg_shift_r;
    if (shifted > SAT_MAX) begin
      x_sat = SAT_MAX[SAMPLE_W-1:0];
    end else if (shifted < SAT_MIN) begin
      x_sat = SAT_MIN[SAMPLE_W-1:0];
    end else begin
      x_sat = shifted[SAMPLE_W-1:0];
    end
  end

  // DC mix written as alpha*(dc - x) + x*65536, a single multiply.
  logic [ALPHA_W-1:0]          alpha_eff;
  logic signed [SAMPLE_W:0]    dc_diff;
  logic signed [MIX_W-1:0]     mix_nxt;

  always_comb begin
    alpha_eff = (cfg_alpha_r > ALPHA_ONE) ? ALPHA_ONE : cfg_alpha_r;
    dc_diff   = {dc_r[SAMPLE_W-1], dc_r} - {x_r[SAMPLE_W-1], x_r};
    mix_nxt   = MIX_W'($signed({1'b0, alpha_eff}) * dc_diff)
              + (MIX_W'(x_r) <<< 16);
  end

  // Divide by 65536 truncating toward zero, then form the corrected sample.
  logic signed [MIX_W-17:0]   dc_quot;
  logic signed [SAMPLE_W-1:0] dc_nxt;
  logic signed [SAMPLE_W-1:0] stored_nxt;

  always_comb begin
    dc_quot = mix_r[MIX_W-1:16];
    if (mix_r[MIX_W-1] && (mix_r[15:0] != 16'd0)) begin
      dc_quot = dc_quot + 1'b1;
    end
    dc_nxt     = dc_quot[SAMPLE_W-1:0];
    stored_nxt = x_r - dc_nxt;
  end

  // Emission of the pending chunk's sample at this position.
  logic [LW-1:0] pos_ext;
  logic [LW-1:0] pos_inc;
  logic          emit_now;
  logic          out_free;

  always_comb begin
    pos_ext  = LW'(pos_r);
    pos_inc  = pos_ext + 1'b1;
    emit_now = emit_r && (pos_ext < plen_r);
    out_free = !out_valid_r || !out_stall;
  end

  // Magnitude and square of the corrected sample.
  logic [SAMPLE_W:0] mag;
  logic signed [2*SAMPLE_W-1:0] sq_full;

  always_comb begin
    mag     = stored_r[SAMPLE_W-1] ? (SAMPLE_W+1)'(-$signed({1'b1, stored_r}))
                                   : {1'b0, stored_r};
    sq_full = stored_r * stored_r;
  end

  // End-of-item accumulation and the chunk decision.
  logic [31:0]           len_wide;
  logic [LW-1:0]         len_eff;
  logic [ENERGY_W-1:0]   energy_sum;
  logic [COUNT_W-1:0]    count_sum;
  logic                  chunk_end;
  logic                  send;
  logic                  rec_mid;
  logic [CHUNKNUM_W-1:0] sent_mid;
  logic [CHUNKNUM_W-1:0] pnum_nxt;
  logic                  stop;

  always_comb begin
    len_wide = 32'(cfg_len_r);
    if (len_wide == 32'd0) begin
      len_eff = LW'(1);
    end else if (len_wide > 32'(MAX_CHUNK)) begin
      len_eff = LW'(MAX_CHUNK);
    end else begin
      len_eff = LW'(len_wide);
    end
    energy_sum = energy_r + ENERGY_W'(sq_r);
    count_sum  = count_r + COUNT_W'(act_r);
    chunk_end  = pos_inc >= len_eff;
    send       = 1'b0;
    rec_mid    = rec_r;
    sent_mid   = sent_r;
    if (!rec_r) begin
      if ((energy_sum > cfg_energy_r) || (count_sum > cfg_count_min_r)) begin
        rec_mid  = 1'b1;
        sent_mid = CHUNKNUM_W'(1);
        send     = 1'b1;
      end
    end else begin
      sent_mid = sent_r + 1'b1;
      send     = 1'b1;
    end
    pnum_nxt = send ? sent_mid : '0;
    // A recording ends once enough chunks after the trigger chunk have gone.
    stop = rec_mid && send && (pnum_nxt != CHUNKNUM_W'(1))
        && (sent_mid >= cfg_rec_chunks_r);
  end

  // Sequencer: next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        state_nxt = S_UPD;
      end
      S_UPD: begin
        if (!emit_now || out_free) begin
          state_nxt = S_SQ;
        end
      end
      S_SQ: begin
        state_nxt = S_END;
      end
      S_END: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Sequencer: control outputs.
  always_comb begin
    in_stall  = 1'b1;
    ram_re    = 1'b0;
    ram_we    = 1'b0;
    upd_go    = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_stall = 1'b0;
        ram_re   = in_valid;
      end
      S_UPD: begin
        upd_go = !emit_now || out_free;
        ram_we = upd_go;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
    in_accept = in_valid && !in_stall;
  end

  // The read of the old entry is done before its write-back in the same
  // step, and the next item is taken only after it, so no forwarding is
  // needed on the store.
  stcr_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (MAX_CHUNK)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (pos_r),
    .wdata (stored_nxt),
    .re    (ram_re),
    .raddr (pos_r),
    .rdata (ram_rdata)
  );

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_shift_r      <= RST_SAMPLE_SHIFT;
      cfg_len_r        <= RST_CHUNK_LENGTH;
      cfg_alpha_r      <= RST_DC_ALPHA_Q16;
      cfg_amp_r        <= RST_AMP_THRESHOLD;
      cfg_energy_r     <= RST_ENERGY_THRESHOLD;
      cfg_count_min_r  <= RST_ACTIVE_COUNT_MIN;
      cfg_rec_chunks_r <= RST_RECORDING_CHUNKS;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SAMPLE_SHIFT:     cfg_shift_r      <= cfg_wdata[SHIFT_W-1:0];
        REG_CHUNK_LENGTH:     cfg_len_r        <= cfg_wdata[LEN_W-1:0];
        REG_DC_ALPHA_Q16:     cfg_alpha_r      <= cfg_wdata[ALPHA_W-1:0];
        REG_AMP_THRESHOLD:    cfg_amp_r        <= cfg_wdata[AMP_W-1:0];
        REG_ENERGY_THRESHOLD: cfg_energy_r     <= cfg_wdata[ENERGY_W-1:0];
        REG_ACTIVE_COUNT_MIN: cfg_count_min_r  <= cfg_wdata[COUNT_W-1:0];
        REG_RECORDING_CHUNKS: cfg_rec_chunks_r <= cfg_wdata[CHUNKNUM_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Datapath registers without reset.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      x_r <= x_sat;
    end
    if (state_r == S_MUL) begin
      mix_r <= mix_nxt;
    end
    if (upd_go) begin
      stored_r <= stored_nxt;
    end
    if (state_r == S_SQ) begin
      sq_r  <= sq_full[SQ_W-1:0];
      act_r <= 32'(mag) > 32'(cfg_amp_r);
    end
    if (upd_go && emit_now) begin
      out_sample_r <= ram_rdata;
      out_index_r  <= INDEX_W'(pos_r);
      out_num_r    <= pnum_r;
      out_first_r  <= pnum_r == CHUNKNUM_W'(1);
      out_last_r   <= pos_inc == plen_r;
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pos_r       <= '0;
      dc_r        <= '0;
      energy_r    <= '0;
      count_r     <= '0;
      rec_r       <= 1'b0;
      sent_r      <= '0;
      emit_r      <= 1'b0;
      pnum_r      <= '0;
      plen_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (upd_go) begin
        dc_r <= dc_nxt;
      end
      if (upd_go && emit_now) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (state_r == S_END) begin
        if (chunk_end) begin
          rec_r    <= stop ? 1'b0 : rec_mid;
          sent_r   <= stop ? '0 : sent_mid;
          emit_r   <= send;
          pnum_r   <= pnum_nxt;
          plen_r   <= send ? pos_inc : '0;
          energy_r <= '0;
          count_r  <= '0;
          pos_r    <= '0;
        end else begin
          energy_r <= energy_sum;
          count_r  <= count_sum;
          pos_r    <= PW'(pos_inc);
        end
      end
    end
  end

  assign out_valid              = out_valid_r;
  assign out_sample             = out_sample_r;
  assign out_sample_index       = out_index_r;
  assign out_chunk_number       = out_num_r;
  assign out_first_of_recording = out_first_r;
  assign out_last_of_chunk      = out_last_r;

`ifndef SYNTH
  // A new result is only ever loaded by the write-back step.
  a_load_from_upd: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_UPD))
    else $error("result appeared outside the write-back step");

  // The chunk position always addresses a real store entry.
  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    32'(pos_r) < 32'(MAX_CHUNK))
    else $error("chunk position beyond the store");

  // A pending chunk always has a length and a chunk number.
  a_pending_len: assert property (@(posedge clk) disable iff (!rst_n)
    emit_r |-> (plen_r != '0) && (pnum_r != '0))
    else $error("pending chunk without length or number");

  // While recording, the chunk count never sits at zero.
  a_rec_count: assert property (@(posedge clk) disable iff (!rst_n)
    rec_r |-> sent_r != '0)
    else $error("recording with a zero chunk count");
`endif

endmodule

FILE: tb/chunk_recorder_checker.sv
`timescale 1ns / 1ps

// Watches the configuration port and both item channels, keeps its own copy of
// the recorder state and compares every sent sample with the predicted one.
module chunk_recorder_checker
  import stcr_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  logic                       in_stall,
  input  logic signed [RAW_W-1:0]    in_raw_word,
  input  logic                       out_valid,
  input  logic                       out_stall,
  input  logic signed [SAMPLE_W-1:0] out_sample,
  input  logic [INDEX_W-1:0]         out_sample_index,
  input  logic [CHUNKNUM_W-1:0]      out_chunk_number,
  input  logic                       out_first_of_recording,
  input  logic                       out_last_of_chunk,
  input  logic                       cfg_we,
  input  logic [CFG_IDX_W-1:0]       cfg_index,
  input  logic [CFG_DATA_W-1:0]      cfg_wdata,
  output int                         sample_mismatches,
  output int                         samples_awaited
);

  typedef struct packed {
    logic [SAMPLE_W-1:0]   sample;
    logic [INDEX_W-1:0]    index;
    logic [CHUNKNUM_W-1:0] chunk;
    logic                  first;
    logic                  last;
  } sent_sample_t;

  // Register copies.
  logic [SHIFT_W-1:0]    k_shift;
  logic [LEN_W-1:0]      k_len;
  logic [ALPHA_W-1:0]    k_alpha;
  logic [AMP_W-1:0]      k_amp;
  logic [ENERGY_W-1:0]   k_energy_thr;
  logic [COUNT_W-1:0]    k_count_min;
  logic [CHUNKNUM_W-1:0] k_rec_chunks;

  // Recorder state.
  logic [SAMPLE_W-1:0]        sample_mem [0:MAX_CHUNK_DEF-1];
  int unsigned                wr_pos;
  logic signed [SAMPLE_W-1:0] dc_est;
  logic [ENERGY_W-1:0]        energy_acc;
  logic [COUNT_W-1:0]         active_cnt;
  bit                         recording;
  logic [CHUNKNUM_W-1:0]      sent_cnt;
  bit                         pend_valid;
  logic [CHUNKNUM_W-1:0]      pend_num;
  int unsigned                pend_len;

  sent_sample_t awaited_samples[$];
  int           mismatch_total;

  // Takes one raw word through the recorder and tells whether it releases a
  // sample of the pending chunk, and which one.
  task automatic record_word(input logic signed [RAW_W-1:0] raw, output bit has_sample,
                             output sent_sample_t predicted);
    int unsigned                len;
    int unsigned                pos;
    logic signed [RAW_W-1:0]    shifted;
    int                         x;
    longint                     alpha;
    longint                     mix;
    longint                     mag;
    longint                     amp_l;
    logic signed [SAMPLE_W-1:0] corr;
    bit                         send;
    if (k_len == 0) len = 1;
    else if (k_len > MAX_CHUNK_DEF) len = MAX_CHUNK_DEF;
    else len = 32'(k_len);
    pos = wr_pos;
    has_sample = 1'b0;
    predicted = '0;
    // The pending chunk's sample at this position goes out before it is overwritten.
    if (pend_valid && pos < pend_len) begin
      has_sample = 1'b1;
      predicted.sample = sample_mem[pos];
      predicted.index = INDEX_W'(pos);
      predicted.chunk = pend_num;
      predicted.first = (pend_num == 1);
      predicted.last = (pos + 1 == pend_len);
    end
    shifted = raw >>> k_shift;
    x = shifted;
    if (x > SAT_MAX) x = SAT_MAX;
    if (x < SAT_MIN) x = SAT_MIN;
    alpha = (k_alpha > ALPHA_ONE) ? 64'd65536 : 64'(k_alpha);
    mix = alpha * longint'(dc_est) + (64'sd65536 - alpha) * longint'(x);
    dc_est = SAMPLE_W'(mix / 64'sd65536);
    corr = SAMPLE_W'(x - int'(dc_est));
    sample_mem[pos] = corr;
    mag = (corr < 0) ? -longint'(corr) : longint'(corr);
    energy_acc = energy_acc + ENERGY_W'(mag * mag);
    amp_l = 64'(k_amp);
    if (mag > amp_l) active_cnt = active_cnt + 1'b1;
    pos++;
    if (pos >= len) begin
      send = 1'b0;
      if (!recording) begin
        if (energy_acc > k_energy_thr || active_cnt > k_count_min) begin
          recording = 1'b1;
          sent_cnt = CHUNKNUM_W'(1);
          send = 1'b1;
        end
      end else begin
        sent_cnt = sent_cnt + 1'b1;
        send = 1'b1;
      end
      pend_valid = send;
      pend_num = send ? sent_cnt : '0;
      pend_len = send ? pos : 0;
      // The trigger chunk never ends a recording by itself.
      if (recording && send && pend_num != 1 && sent_cnt >= k_rec_chunks) begin
        recording = 1'b0;
        sent_cnt = '0;
      end
      energy_acc = '0;
      active_cnt = '0;
      pos = 0;
    end
    wr_pos = pos;
  endtask

  always @(posedge clk) begin : watch
    bit           has_sample;
    sent_sample_t predicted;
    sent_sample_t seen;
    if (!rst_n) begin
      k_shift = RST_SAMPLE_SHIFT;
      k_len = RST_CHUNK_LENGTH;
      k_alpha = RST_DC_ALPHA_Q16;
      k_amp = RST_AMP_THRESHOLD;
      k_energy_thr = RST_ENERGY_THRESHOLD;
      k_count_min = RST_ACTIVE_COUNT_MIN;
      k_rec_chunks = RST_RECORDING_CHUNKS;
      wr_pos = 0;
      dc_est = '0;
      energy_acc = '0;
      active_cnt = '0;
      recording = 1'b0;
      sent_cnt = '0;
      pend_valid = 1'b0;
      pend_num = '0;
      pend_len = 0;
      awaited_samples.delete();
      mismatch_total = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_SAMPLE_SHIFT:     k_shift = cfg_wdata[SHIFT_W-1:0];
          REG_CHUNK_LENGTH:     k_len = cfg_wdata[LEN_W-1:0];
          REG_DC_ALPHA_Q16:     k_alpha = cfg_wdata[ALPHA_W-1:0];
          REG_AMP_THRESHOLD:    k_amp = cfg_wdata[AMP_W-1:0];
          REG_ENERGY_THRESHOLD: k_energy_thr = cfg_wdata[ENERGY_W-1:0];
          REG_ACTIVE_COUNT_MIN: k_count_min = cfg_wdata[COUNT_W-1:0];
          REG_RECORDING_CHUNKS: k_rec_chunks = cfg_wdata[CHUNKNUM_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        record_word(in_raw_word, has_sample, predicted);
        if (has_sample) awaited_samples.push_back(predicted);
      end
      if (out_valid && !out_stall) begin
        seen.sample = out_sample;
        seen.index = out_sample_index;
        seen.chunk = out_chunk_number;
        seen.first = out_first_of_recording;
        seen.last = out_last_of_chunk;
        if (awaited_samples.size() == 0) begin
          mismatch_total++;
          if (mismatch_total <= 10)
            $display("%0t: unexpected item: sample %0d index %0d chunk %0d first %0b last %0b",
                     $realtime, $signed(seen.sample), seen.index, seen.chunk, seen.first,
                     seen.last);
        end else begin
          predicted = awaited_samples.pop_front();
          if (seen !== predicted) begin
            mismatch_total++;
            if (mismatch_total <= 10) begin
              $display("%0t: expected sample %0d index %0d chunk %0d first %0b last %0b",
                       $realtime, $signed(predicted.sample), predicted.index, predicted.chunk,
                       predicted.first, predicted.last);
              $display("  but got sample %0d index %0d chunk %0d first %0b last %0b",
                       $signed(seen.sample), seen.index, seen.chunk, seen.first, seen.last);
            end
          end
        end
      end
    end
    sample_mismatches <= mismatch_total;
    samples_awaited <= awaited_samples.size();
  end

endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps

// Top of the recorder test. This module only makes stimulus and gives the
// verdict; the checker beside the block predicts and compares every item.
module tb;
  import stcr_pkg::*;

  // Cycles the receiver holds off once, so that the block fills up.
  localparam int LONG_HOLD = 400;
  // Quiet cycles after the last awaited item before a register is written.
  // A step's result is loaded into the output register before the step ends.
  localparam int SETTLE_CYCLES = 20;
  localparam int RANDOM_PHASES = 20;
  localparam logic [ENERGY_W-1:0] ENERGY_ALL_ONES = '1;

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       in_valid = 1'b0;
  logic                       in_stall;
  logic signed [RAW_W-1:0]    in_raw_word = '0;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic signed [SAMPLE_W-1:0] out_sample;
  logic [INDEX_W-1:0]         out_sample_index;
  logic [CHUNKNUM_W-1:0]      out_chunk_number;
  logic                       out_first_of_recording;
  logic                       out_last_of_chunk;
  logic                       cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]       cfg_index = '0;
  logic [CFG_DATA_W-1:0]      cfg_wdata = '0;

  int sample_mismatches;
  int samples_awaited;

  // Idle pattern state: a calm side idles not at all for a while.
  bit in_calm = 1'b0;
  bit out_calm = 1'b0;
  int words_sent = 0;
  int samples_taken = 0;
  // Set by the stimulus to ask the receiver for one long hold-off.
  bit hold_off_req = 1'b0;
  // Loud or quiet stretch of the generated audio.
  bit loud = 1'b0;

  always #10 clk = ~clk;

  sound_triggered_chunk_recorder_core dut (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .in_valid               (in_valid),
    .in_stall               (in_stall),
    .in_raw_word            (in_raw_word),
    .out_valid              (out_valid),
    .out_stall              (out_stall),
    .out_sample             (out_sample),
    .out_sample_index       (out_sample_index),
    .out_chunk_number       (out_chunk_number),
    .out_first_of_recording (out_first_of_recording),
    .out_last_of_chunk      (out_last_of_chunk),
    .cfg_we                 (cfg_we),
    .cfg_index              (cfg_index),
    .cfg_wdata              (cfg_wdata)
  );

  chunk_recorder_checker sample_check (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .in_valid               (in_valid),
    .in_stall               (in_stall),
    .in_raw_word            (in_raw_word),
    .out_valid              (out_valid),
    .out_stall              (out_stall),
    .out_sample             (out_sample),
    .out_sample_index       (out_sample_index),
    .out_chunk_number       (out_chunk_number),
    .out_first_of_recording (out_first_of_recording),
    .out_last_of_chunk      (out_last_of_chunk),
    .cfg_we                 (cfg_we),
    .cfg_index              (cfg_index),
    .cfg_wdata              (cfg_wdata),
    .sample_mismatches      (sample_mismatches),
    .samples_awaited        (samples_awaited)
  );

  // Wait drawn for every item on either side; a calm side does not wait.
  function automatic int draw_idle(bit calm);
    return calm ? 0 : $urandom_range(0, 6);
  endfunction

  // Offers one raw word and returns in the step at which it was accepted.
  // Valid stays high into the next word when no gap is drawn, so it is never
  // lowered and raised in the same step.
  task automatic send_word(input logic [RAW_W-1:0] word);
    int gap;
    gap = draw_idle(in_calm);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_raw_word <= word;
    do @(posedge clk); while (in_stall);
    words_sent++;
    if (words_sent % 40 == 0) in_calm = ($urandom_range(0, 3) == 0);
  endtask

  // Sends audio made of loud and quiet stretches, with some full-scale noise.
  task automatic run_words(input int count);
    logic [RAW_W-1:0] word;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 15) == 0) loud = ~loud;
      word = $urandom;
      if ($urandom_range(0, 9) != 0)
        word = $signed(word) >>> (loud ? $urandom_range(0, 8) : $urandom_range(18, 31));
      send_word(word);
    end
  endtask

  // Drops valid and waits until every awaited item has come and the block has
  // had time to finish a step that causes no item.
  task automatic settle();
    in_valid <= 1'b0;
    repeat (2) @(posedge clk);
    while (samples_awaited != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // One register write; the caller lowers the write enable after the batch.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
  endtask

  task automatic program_settings(input logic [SHIFT_W-1:0] shift, input logic [LEN_W-1:0] len,
                                  input logic [ALPHA_W-1:0] alpha,
                                  input logic [AMP_W-1:0] amp,
                                  input logic [ENERGY_W-1:0] energy_thr,
                                  input logic [COUNT_W-1:0] count_min,
                                  input logic [CHUNKNUM_W-1:0] rec_chunks);
    write_reg(REG_SAMPLE_SHIFT, CFG_DATA_W'(shift));
    write_reg(REG_CHUNK_LENGTH, CFG_DATA_W'(len));
    write_reg(REG_DC_ALPHA_Q16, CFG_DATA_W'(alpha));
    write_reg(REG_AMP_THRESHOLD, CFG_DATA_W'(amp));
    write_reg(REG_ENERGY_THRESHOLD, CFG_DATA_W'(energy_thr));
    write_reg(REG_ACTIVE_COUNT_MIN, CFG_DATA_W'(count_min));
    write_reg(REG_RECORDING_CHUNKS, CFG_DATA_W'(rec_chunks));
    cfg_we <= 1'b0;
  endtask

  // Receiver: draws a stall for every item, and once stalls for a long
  // stretch when the stimulus asks for it.
  initial begin : result_sink
    int hold;
    forever begin
      hold = draw_idle(out_calm);
      if (hold_off_req) begin
        hold = LONG_HOLD;
        hold_off_req = 1'b0;
      end
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
      samples_taken++;
      if (samples_taken % 30 == 0) out_calm = ($urandom_range(0, 3) == 0);
    end
  end

  // Guard against a hung block.
  initial begin : run_limit
    #10ms;
    $display("sound_triggered_chunk_recorder_core test failed");
    $finish;
  end

  initial begin : stimulus
    logic [SHIFT_W-1:0]    shift;
    logic [LEN_W-1:0]      len;
    logic [ALPHA_W-1:0]    alpha;
    logic [AMP_W-1:0]      amp;
    logic [ENERGY_W-1:0]   energy_thr;
    logic [COUNT_W-1:0]    count_min;
    logic [CHUNKNUM_W-1:0] rec_chunks;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Full-scale words with no shift and a frozen DC estimate, so the stored
    // samples are the saturated inputs. Thresholds at zero make the first
    // chunk trigger, and a limit of one still gives two sent chunks. The
    // third chunk is silent and must not start a new recording.
    program_settings(5'd0, 12'd4, ALPHA_ONE, 16'd0, '0, 12'd0, 8'd1);
    send_word(32'h7FFF_FFFF);
    send_word(32'h8000_0000);
    send_word(32'd32767);
    send_word(-32'sd32768);
    send_word(32'd32768);
    send_word(-32'sd32769);
    send_word(32'd1);
    send_word(32'hFFFF_FFFF);
    repeat (4) send_word(32'd0);
    settle();

    // Largest shift leaves only the sign, a zero length acts as one sample,
    // an alpha above one acts as one and a limit of zero gives two chunks.
    program_settings(5'd31, 12'd0, '1, '1, '0, '1, 8'd0);
    send_word(32'h8000_0000);
    send_word(32'h7FFF_FFFF);
    send_word(32'hFFFF_FFFF);
    send_word(32'd1);
    send_word(32'h8000_0000);
    settle();

    // An oversized length acts as the store size; then the length drops
    // below the position already reached, so the next write ends the chunk.
    program_settings(5'd14, '1, RST_DC_ALPHA_Q16, 16'd32768, ENERGY_ALL_ONES, 12'd0, 8'd255);
    loud = 1'b1;
    run_words(3);
    settle();
    write_reg(REG_CHUNK_LENGTH, CFG_DATA_W'(2));
    cfg_we <= 1'b0;
    run_words(3);
    settle();

    // Every chunk is sent and the receiver holds off for a long stretch, so
    // the output register fills and the block stalls its input.
    program_settings(5'd16, 12'd8, ALPHA_ONE, 16'd0, '0, 12'd0, 8'd255);
    hold_off_req = 1'b1;
    run_words(120);
    settle();

    // Random settings between phases; the recording state and the chunk
    // position carry over, so pending chunks meet longer and shorter chunks.
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      case ($urandom_range(0, 4))
        0: shift = 5'd0;
        1: shift = 5'd31;
        default: shift = SHIFT_W'($urandom_range(0, 31));
      endcase
      case ($urandom_range(0, 19))
        0: len = 12'd0;
        1: len = '1;
        2: len = LEN_W'($urandom_range(100, 300));
        3, 4, 5: len = LEN_W'($urandom_range(13, 64));
        default: len = LEN_W'($urandom_range(1, 12));
      endcase
      case ($urandom_range(0, 5))
        0: alpha = '0;
        1: alpha = ALPHA_ONE;
        2: alpha = '1;
        3: alpha = RST_DC_ALPHA_Q16;
        4: alpha = ALPHA_W'($urandom_range(0, 131071));
        default: alpha = ALPHA_W'($urandom_range(60000, 65536));
      endcase
      case ($urandom_range(0, 4))
        0: amp = '0;
        1: amp = 16'd32768;
        2: amp = '1;
        default: amp = AMP_W'($urandom_range(0, 32768));
      endcase
      case ($urandom_range(0, 5))
        0: energy_thr = '0;
        1: energy_thr = ENERGY_ALL_ONES;
        2: energy_thr = ENERGY_W'({$urandom, $urandom});
        default: energy_thr = ENERGY_W'($urandom_range(0, 1 << 22));
      endcase
      case ($urandom_range(0, 4))
        0: count_min = '0;
        1: count_min = '1;
        default: count_min = COUNT_W'($urandom_range(0, 16));
      endcase
      case ($urandom_range(0, 5))
        0: rec_chunks = 8'd0;
        1: rec_chunks = 8'd1;
        2: rec_chunks = 8'd255;
        default: rec_chunks = CHUNKNUM_W'($urandom_range(1, 6));
      endcase
      program_settings(shift, len, alpha, amp, energy_thr, count_min, rec_chunks);
      run_words($urandom_range(60, 110));
      settle();
    end

    // Everything is accepted; give the last items time to come out.
    for (int i = 0; i < 20000 && samples_awaited != 0; i++) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (sample_mismatches == 0 && samples_awaited == 0) begin
      $display("sound_triggered_chunk_recorder_core test passed");
    end else begin
      $display("sound_triggered_chunk_recorder_core test failed");
    end
    $finish;
  end

endmodule

FILE: sound_triggered_chunk_recorder_core.f
hdl/stcr_pkg.sv
hdl/stcr_ram.sv
hdl/sound_triggered_chunk_recorder_core.sv
tb/chunk_recorder_checker.sv
tb/tb.sv
